@@ design/hslc_pkg.sv @@
// Package for the HSL to RGB converter: widths, fixed-point constants and shared types.
`default_nettype none

package hslc_pkg;

    // Fraction bits of the hue, saturation and lightness inputs (1.0 = 2^FRAC_BITS)
    localparam int FRAC_BITS = 15;

    localparam int HUE_W = FRAC_BITS;           // hue port width
    localparam int IN_W  = FRAC_BITS + 1;       // saturation/lightness width, holds 1.0
    localparam int T_W   = FRAC_BITS + 2;       // 3*hue, below 3.0
    localparam int K_W   = FRAC_BITS + 1;       // ramp weight, 0 .. 1.0
    localparam int P_W   = 2 * FRAC_BITS + 1;   // bounds at 2*FRAC_BITS fraction bits
    localparam int ACC_W = 3 * FRAC_BITS + 1;   // ramp value at 3*FRAC_BITS fraction bits
    localparam int OUT_W = 16;                  // color channel width
    localparam int RES_W = OUT_W + 1;           // rounded channel before saturation
    localparam int RES_SHIFT = 3 * FRAC_BITS - OUT_W;

    // 1.0 at the input scale and one third of a turn at the 3*hue scale
    localparam logic [IN_W-1:0] ONE_IN  = IN_W'(1 << FRAC_BITS);
    localparam logic [IN_W-1:0] HALF_IN = IN_W'(1 << (FRAC_BITS - 1));
    localparam logic [T_W:0]    ONE_T   = (T_W + 1)'(1 << FRAC_BITS);
    localparam logic [T_W:0]    TWO_T   = (T_W + 1)'(2 << FRAC_BITS);
    localparam logic [T_W:0]    THREE_T = (T_W + 1)'(3 << FRAC_BITS);

    // Rounding constant: one half of the output LSB
    localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (RES_SHIFT - 1);

    // Load enables of the pipeline stages shared with the channel units
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
    } stage_en_t;

endpackage

`default_nettype wire

@@ design/hslc_chan.sv @@
// One color channel: hue ramp weight, scaling multiply, rounding and saturation.
`default_nettype none

module hslc_chan (
    input  wire logic                          clk,
    input  wire hslc_pkg::stage_en_t           en,
    input  wire logic [hslc_pkg::T_W-1:0]      t,      // 3*hue, stage 1
    input  wire logic [hslc_pkg::P_W-1:0]      dw,     // m2 - m1, stage 2
    input  wire logic [hslc_pkg::P_W-1:0]      m1w,    // lower bound, stage 3
    output logic      [hslc_pkg::OUT_W-1:0]    chan
);

    localparam int F = hslc_pkg::FRAC_BITS;

    logic [hslc_pkg::K_W-1:0]                   k_reg, k_next;
    logic [hslc_pkg::T_W:0]                     two_t;
    logic [hslc_pkg::T_W:0]                     fall;
    logic [hslc_pkg::P_W+hslc_pkg::K_W-1:0]     prod_reg, prod_next;
    logic [hslc_pkg::ACC_W-1:0]                 sum;
    logic [hslc_pkg::RES_W-1:0]                 res;
    logic [hslc_pkg::OUT_W-1:0]                 chan_reg, chan_next;

    // Piecewise ramp weight: rising sixth, flat top, falling sixth, floor
    always_comb
    begin
        two_t = {t, 1'b0};
        fall  = (hslc_pkg::TWO_T << 1) - two_t;
        if (two_t < hslc_pkg::ONE_T)
        begin
            k_next = two_t[hslc_pkg::K_W-1:0];
        end
        else if (two_t < hslc_pkg::THREE_T)
        begin
            k_next = hslc_pkg::ONE_IN;
        end
        else if ({1'b0, t} < hslc_pkg::TWO_T)
        begin
            k_next = fall[hslc_pkg::K_W-1:0];
        end
        else
        begin
            k_next = '0;
        end
    end

    // Span times weight
    assign prod_next = dw * k_reg;

    // m1 + d*k, rounded half up to 16 bits, 1.0 saturates
    always_comb
    begin
        sum = {m1w, {F{1'b0}}} + prod_reg[hslc_pkg::ACC_W-1:0] + hslc_pkg::RND;
        res = hslc_pkg::RES_W'(sum >> hslc_pkg::RES_SHIFT);
        chan_next = res[hslc_pkg::OUT_W] ? '1 : res[hslc_pkg::OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.ld2)
        begin
            k_reg <= k_next;
        end
        if (en.ld3)
        begin
            prod_reg <= prod_next;
        end
        if (en.ld4)
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

@@ design/hsl_to_rgb_convert_core.sv @@
// HSL to RGB converter: four register stages, one pixel per clock while out_ready does not stall the output.
// A pixel accepted at a clock edge passes through the stage 1, 2, 3 and 4 registers in turn; stage 4 drives the output.
// Throughput: one pixel per clock unless the output stalls; the stages move independently, so bubbles close up.
// A stalled output holds its pixel while earlier stages keep filling behind it.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data registers keep no reset.
`default_nettype none

module hsl_to_rgb_convert_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [hslc_pkg::HUE_W-1:0]    hue_frac,
    input  wire logic [hslc_pkg::IN_W-1:0]     saturation,
    input  wire logic [hslc_pkg::IN_W-1:0]     lightness,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [hslc_pkg::OUT_W-1:0]    red,
    output logic      [hslc_pkg::OUT_W-1:0]    green,
    output logic      [hslc_pkg::OUT_W-1:0]    blue
);

    localparam int F = hslc_pkg::FRAC_BITS;

    // Stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic ld1;
    hslc_pkg::stage_en_t en;

    // Stage 1 signals
    logic [hslc_pkg::IN_W-1:0]      s_c, l_c;
    logic [hslc_pkg::T_W:0]         t_g, t_r_sum, t_b_sum, t_r, t_b;
    logic [2*hslc_pkg::IN_W-1:0]    ls_prod;
    logic [hslc_pkg::T_W-1:0]       tr_s1_reg, tg_s1_reg, tb_s1_reg;
    logic [hslc_pkg::P_W-1:0]       p_s1_reg;
    logic [hslc_pkg::IN_W-1:0]      s_s1_reg, l_s1_reg;

    // Stage 2 signals
    logic [hslc_pkg::P_W-1:0]       lf, sf, diff;
    logic [hslc_pkg::P_W:0]         m1_wide;
    logic [hslc_pkg::P_W-1:0]       m1w_next, dw_next;
    logic [hslc_pkg::P_W-1:0]       m1w_s2_reg, dw_s2_reg;

    // Stage 3 signals
    logic [hslc_pkg::P_W-1:0]       m1w_s3_reg;

    // Elastic pipeline: a stage loads when the next one is empty or loading
    always_comb
    begin
        rdy4 = !v4_reg || out_ready;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        ld1    = in_valid && rdy1;
        en.ld2 = v1_reg && rdy2;
        en.ld3 = v2_reg && rdy3;
        en.ld4 = v3_reg && rdy4;
    end

    assign in_ready  = rdy1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: clamp, l*s, hue scaled to thirds and offset per channel
    always_comb
    begin
        s_c = (saturation > hslc_pkg::ONE_IN) ? hslc_pkg::ONE_IN : saturation;
        l_c = (lightness > hslc_pkg::ONE_IN) ? hslc_pkg::ONE_IN : lightness;
        ls_prod = l_c * s_c;
        t_g = (hslc_pkg::T_W + 1)'(hue_frac) + (hslc_pkg::T_W + 1)'({hue_frac, 1'b0});
        t_r_sum = t_g + hslc_pkg::ONE_T;
        t_b_sum = t_g + hslc_pkg::TWO_T;
        t_r = (t_r_sum >= hslc_pkg::THREE_T) ? t_r_sum - hslc_pkg::THREE_T : t_r_sum;
        t_b = (t_b_sum >= hslc_pkg::THREE_T) ? t_b_sum - hslc_pkg::THREE_T : t_b_sum;
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            tr_s1_reg <= t_r[hslc_pkg::T_W-1:0];
            tg_s1_reg <= t_g[hslc_pkg::T_W-1:0];
            tb_s1_reg <= t_b[hslc_pkg::T_W-1:0];
            p_s1_reg  <= ls_prod[hslc_pkg::P_W-1:0];
            s_s1_reg  <= s_c;
            l_s1_reg  <= l_c;
        end
    end

    // Stage 2: bounds m1 and span d = m2 - m1 at 2*FRAC_BITS fraction bits
    always_comb
    begin
        lf = {l_s1_reg, {F{1'b0}}};
        sf = {s_s1_reg, {F{1'b0}}};
        m1_wide = {1'b0, lf} + {1'b0, p_s1_reg} - {1'b0, sf};
        diff = sf - p_s1_reg;
        if (l_s1_reg <= hslc_pkg::HALF_IN)
        begin
            // m2 = l*(1+s): m1 = l - l*s, d = 2*l*s
            m1w_next = lf - p_s1_reg;
            dw_next  = {p_s1_reg[hslc_pkg::P_W-2:0], 1'b0};
        end
        else
        begin
            // m2 = l + s - l*s: m1 = l - s + l*s, d = 2*(s - l*s)
            m1w_next = m1_wide[hslc_pkg::P_W-1:0];
            dw_next  = {diff[hslc_pkg::P_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld2)
        begin
            m1w_s2_reg <= m1w_next;
            dw_s2_reg  <= dw_next;
        end
        if (en.ld3)
        begin
            m1w_s3_reg <= m1w_s2_reg;
        end
    end

    // Stages 2 to 4 per channel
    hslc_chan u_red (
        .clk  (clk),
        .en   (en),
        .t    (tr_s1_reg),
        .dw   (dw_s2_reg),
        .m1w  (m1w_s3_reg),
        .chan (red)
    );

    hslc_chan u_green (
        .clk  (clk),
        .en   (en),
        .t    (tg_s1_reg),
        .dw   (dw_s2_reg),
        .m1w  (m1w_s3_reg),
        .chan (green)
    );

    hslc_chan u_blue (
        .clk  (clk),
        .en   (en),
        .t    (tb_s1_reg),
        .dw   (dw_s2_reg),
        .m1w  (m1w_s3_reg),
        .chan (blue)
    );

    // A full stage 3 moves into a free or draining output register
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (!v4_reg || out_ready)) |=> out_valid)
        else $error("stage 3 pixel did not reach the output");

    // An output that is taken frees the whole chain
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // Upper bound m1 + d stays within 1.0
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (({1'b0, m1w_s2_reg} + {1'b0, dw_s2_reg})
                    <= ((hslc_pkg::P_W + 1)'(1) << (2 * F))))
        else $error("HSL bounds out of range");

endmodule

`default_nettype wire
